// File: hw/rtl/sra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Section RVA translator package
// Shared types and constants: region entry layout, scan result word,
// status codes, request kinds, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package sra_pkg;

	localparam int unsigned WORD_W    = 32;
	localparam int unsigned CFG_IDX_W = 1;

	// top of the 32-bit address space, as a 33-bit value
	localparam logic [WORD_W:0] ADDR_SPAN = {1'b1, {WORD_W{1'b0}}};

	// request kinds (tuser)
	localparam logic REQ_ADD   = 1'b0;
	localparam logic REQ_XLATE = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SIZE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FILE_SIZE   = 1'b1;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_PAST_FILE = 3'd1,
		ST_AMBIGUOUS = 3'd2,
		ST_OVERLAP   = 3'd3,
		ST_FULL      = 3'd4,
		ST_UNMAPPED  = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PRE1,
		S_PRE2,
		S_SCAN,
		S_HIT,
		S_FINISH
	} sra_state_t;

	// one stored region
	typedef struct packed {
		logic [WORD_W-1:0] start;
		logic [WORD_W-1:0] length;
		logic [WORD_W-1:0] foff;
	} region_t;

	// request view seen by the compare unit
	typedef struct packed {
		logic              is_add;
		logic [WORD_W-1:0] rva;
		logic [WORD_W:0]   mapped_end;
	} probe_t;

	// compare unit result for one entry
	typedef struct packed {
		logic              valid;
		logic              hit;
		logic [WORD_W-1:0] length;
		logic [WORD_W-1:0] foff;
		logic [WORD_W-1:0] delta;
	} match_t;

endpackage

// File: hw/rtl/sra_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region table
// Single-port-write, single-port-read memory of region entries with a
// registered read word and a matching read-valid flag.
// ----------------------------------------------------------------------------
module sra_table #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned IDX_W = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_idx,
	input  sra_pkg::region_t wr_data,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_idx,
	output sra_pkg::region_t rd_data,
	output logic             rd_valid
);
	import sra_pkg::*;

	region_t mem_q [DEPTH];
	region_t rd_data_q;
	logic    rd_valid_q;

	// storage: no reset, entries are only read below the fill count
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_idx];
		end
	end

	// read-valid is the registered read strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= rd_en;
		end
	end

	assign rd_data  = rd_data_q;
	assign rd_valid = rd_valid_q;

endmodule

// File: hw/rtl/sra_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region compare unit
// Shared comparator: tests one table entry per cycle against the request,
// overlap for adds and containment for translates, and registers the outcome.
// ----------------------------------------------------------------------------
module sra_match (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  sra_pkg::region_t entry,
	input  sra_pkg::probe_t  probe,
	output sra_pkg::match_t  result
);
	import sra_pkg::*;

	logic [WORD_W:0]   entry_end;
	logic [WORD_W-1:0] delta;
	logic              overlap;
	logic              contain;
	logic              valid_s1;
	logic              hit_s1;
	logic [WORD_W-1:0] length_s1;
	logic [WORD_W-1:0] foff_s1;
	logic [WORD_W-1:0] delta_s1;

	// compare logic
	always_comb begin
		entry_end = {1'b0, entry.start} + {1'b0, entry.length};
		delta     = probe.rva - entry.start;
		overlap   = ({1'b0, probe.rva} < entry_end) &&
		            ({1'b0, entry.start} < probe.mapped_end);
		contain   = (entry.start <= probe.rva) && (delta < entry.length);
	end

	// control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			hit_s1   <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			hit_s1   <= in_valid && (probe.is_add ? overlap : contain);
		end
	end

	// payload
	always_ff @(posedge clk) begin
		length_s1 <= entry.length;
		foff_s1   <= entry.foff;
		delta_s1  <= delta;
	end

	assign result = '{valid: valid_s1, hit: hit_s1, length: length_s1,
	                  foff: foff_s1, delta: delta_s1};

endmodule

// File: hw/rtl/section_rva_translator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Section RVA translator
// Keeps a table of disjoint mapped regions and maps addresses to file offsets.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries requests: tuser is the request kind (add region or
//   translate), tdata the address, sizes, file offset and query length.
//   m_axis returns one word per request: status, file offset and span end.
//   cfg writes header_size (index 0) and file_size (index 1); it is always
//   ready and must only be used while no request is in flight.
// Timing:
//   A request passes through PRE1 and PRE2 for the early checks; one that
//   they settle goes straight to FINISH, any other scans the stored regions:
//   one shared comparator fed by the single table read port visits one entry
//   a cycle, and the scan stops at the first hit.
//   Requests are taken one at a time; s_axis_tready is high when idle.
// Reset:
//   arst_n clears the region count, both registers and all handshakes;
//   table contents are left as they are and are never read before written.
// Back-pressure:
//   The result sits in an output register; a new request may be taken while
//   it waits, and that request holds its own result until the word drains.
// ----------------------------------------------------------------------------
module section_rva_translator #(
	parameter int unsigned MAX_REGIONS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// requests
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [31:0] rva, [63:32] vsize, [95:64] raw_size,
	// [127:96] file_offset, [159:128] query_length
	input  logic [159:0]                    s_axis_tdata,
	// [0] req_type
	input  logic                            s_axis_tuser,
	// results
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [2:0] status, [34:3] out_offset, [66:35] span_end, [71:67] zero
	output logic [71:0]                     m_axis_tdata,
	// configuration
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sra_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sra_pkg::WORD_W-1:0]      cfg_data
);
	import sra_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_REGIONS + 1);
	localparam int unsigned IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REGIONS);

	sra_state_t state_q, state_d;

	// configuration registers
	logic [WORD_W-1:0] header_size_q;
	logic [WORD_W-1:0] file_size_q;

	// request registers
	logic              req_type_q;
	logic [WORD_W-1:0] rva_q;
	logic [WORD_W-1:0] vsize_q;
	logic [WORD_W-1:0] raw_q;
	logic [WORD_W-1:0] foff_q;
	logic [WORD_W-1:0] qlen_q;
	logic [WORD_W-1:0] mapped_q;
	logic              past_q;
	logic [WORD_W:0]   mapped_end_q;

	// table bookkeeping
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  rd_idx_q;

	// captured hit entry
	logic [WORD_W-1:0] hit_len_q;
	logic [WORD_W-1:0] hit_foff_q;
	logic [WORD_W-1:0] hit_delta_q;

	// pending result and output word
	status_t           res_st_q;
	logic [WORD_W-1:0] res_off_q;
	logic [WORD_W-1:0] res_end_q;
	logic              m_valid_q;
	status_t           m_st_q;
	logic [WORD_W-1:0] m_off_q;
	logic [WORD_W-1:0] m_end_q;

	// datapath between table and compare unit
	region_t           rd_data;
	logic              rd_valid;
	region_t           wr_data;
	probe_t            probe;
	match_t            mres;

	// sequencer decisions
	logic              accept;
	logic              is_add;
	logic [WORD_W:0]   add_end;
	logic [WORD_W:0]   xl_end;
	logic              ambig;
	logic              in_header;
	logic              pre2_scan;
	logic              scan_hit;
	logic              scan_done;
	logic              out_free;
	logic              rd_en;
	logic              wr_en;
	logic              res_load;
	status_t           res_st;
	logic [WORD_W-1:0] res_off;
	logic [WORD_W-1:0] res_end;

	assign is_add   = (req_type_q == REQ_ADD);
	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;

	// request checks and scan outcome
	always_comb begin
		add_end   = {1'b0, rva_q} + {1'b0, mapped_q};
		xl_end    = {1'b0, rva_q} + {1'b0, qlen_q};
		in_header = rva_q < header_size_q;
		ambig     = (add_end > ADDR_SPAN) || ((mapped_q != '0) && in_header);
		if (is_add) begin
			pre2_scan = !past_q && !ambig && (mapped_q != '0);
		end else begin
			pre2_scan = !in_header;
		end
		scan_hit  = mres.hit;
		scan_done = (rd_idx_q == count_q) && !rd_valid && !mres.valid;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_PRE1;
			end
			S_PRE1: state_d = S_PRE2;
			S_PRE2: begin
				state_d = pre2_scan ? S_SCAN : S_FINISH;
			end
			S_SCAN: begin
				if (scan_hit) state_d = is_add ? S_FINISH : S_HIT;
				else if (scan_done) state_d = S_FINISH;
			end
			S_HIT: state_d = S_FINISH;
			S_FINISH: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_axis_tready = (state_q == S_IDLE);
		rd_en         = (state_q == S_SCAN) && (rd_idx_q != count_q) && !scan_hit;
		wr_en         = 1'b0;
		res_load      = 1'b0;
		res_st        = ST_OK;
		res_off       = '0;
		res_end       = '0;
		case (state_q)
			S_PRE2: begin
				res_load = !pre2_scan;
				if (is_add) begin
					if (past_q) res_st = ST_PAST_FILE;
					else if (ambig) res_st = ST_AMBIGUOUS;
					else res_st = ST_OK;
				end else if (xl_end > {1'b0, header_size_q}) begin
					res_st = ST_UNMAPPED;
				end else begin
					res_off = rva_q;
					res_end = header_size_q;
				end
			end
			S_SCAN: begin
				if (scan_hit) begin
					res_load = is_add;
					res_st   = ST_OVERLAP;
				end else if (scan_done) begin
					res_load = 1'b1;
					if (!is_add) res_st = ST_UNMAPPED;
					else if (count_q >= CNT_MAX) res_st = ST_FULL;
					else wr_en = 1'b1;
				end
			end
			S_HIT: begin
				res_load = 1'b1;
				if (qlen_q > (hit_len_q - hit_delta_q)) begin
					res_st = ST_UNMAPPED;
				end else begin
					res_off = hit_foff_q + hit_delta_q;
					res_end = hit_foff_q + hit_len_q;
				end
			end
			default: ;
		endcase
	end

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			header_size_q <= '0;
			file_size_q   <= '0;
			count_q       <= '0;
			rd_idx_q      <= '0;
			m_valid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_HEADER_SIZE: header_size_q <= cfg_data;
					CFG_FILE_SIZE:   file_size_q   <= cfg_data;
					default: ;
				endcase
			end
			if (wr_en) count_q <= count_q + 1'b1;
			if (state_q == S_PRE2) rd_idx_q <= '0;
			else if (rd_en) rd_idx_q <= rd_idx_q + 1'b1;
			if (state_q == S_FINISH && out_free) m_valid_q <= 1'b1;
			else if (m_axis_tready) m_valid_q <= 1'b0;
		end
	end

	// request, precheck and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_q <= s_axis_tuser;
			rva_q      <= s_axis_tdata[31:0];
			vsize_q    <= s_axis_tdata[63:32];
			raw_q      <= s_axis_tdata[95:64];
			foff_q     <= s_axis_tdata[127:96];
			qlen_q     <= s_axis_tdata[159:128];
		end
		if (state_q == S_PRE1) begin
			past_q   <= ({1'b0, foff_q} + {1'b0, raw_q}) > {1'b0, file_size_q};
			mapped_q <= ((vsize_q != '0) && (vsize_q < raw_q)) ? vsize_q : raw_q;
		end
		if (state_q == S_PRE2) mapped_end_q <= add_end;
		if (state_q == S_SCAN && scan_hit) begin
			hit_len_q   <= mres.length;
			hit_foff_q  <= mres.foff;
			hit_delta_q <= mres.delta;
		end
		if (res_load) begin
			res_st_q  <= res_st;
			res_off_q <= res_off;
			res_end_q <= res_end;
		end
		if (state_q == S_FINISH && out_free) begin
			m_st_q  <= res_st_q;
			m_off_q <= res_off_q;
			m_end_q <= res_end_q;
		end
	end

	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {5'b0, m_end_q, m_off_q, m_st_q};

	assign wr_data = '{start: rva_q, length: mapped_q, foff: foff_q};
	assign probe   = '{is_add: is_add, rva: rva_q, mapped_end: mapped_end_q};

	sra_table #(
		.DEPTH (MAX_REGIONS),
		.IDX_W (IDX_W)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_idx   (count_q[IDX_W-1:0]),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_idx   (rd_idx_q[IDX_W-1:0]),
		.rd_data  (rd_data),
		.rd_valid (rd_valid)
	);

	sra_match u_match (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rd_valid),
		.entry    (rd_data),
		.probe    (probe),
		.result   (mres)
	);

endmodule
